[rtl/ifba_pkg.sv]
// ----------------------------------------------------------------------------
// ifba_pkg
// Shared types and constants of the interval free block allocator.
// ----------------------------------------------------------------------------
package ifba_pkg;

	localparam int MAX_INTERVALS = 32;
	localparam int BLOCK_BITS    = 32;
	// table fields carry one spare bit: a start may reach 2^BLOCK_BITS
	localparam int EW            = BLOCK_BITS + 1;
	localparam int AW            = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CW            = $clog2(MAX_INTERVALS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_INTERVALS);

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_GROW  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOSPACE   = 2'd1,
		STS_FULL      = 2'd2,
		STS_UNCHANGED = 2'd3
	} sts_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] block_number;
		logic [31:0] target_capacity;
	} req_t;

	typedef struct packed {
		logic [31:0] allocated_block;
		logic [1:0]  status;
		logic [31:0] blocks_in_use;
	} rsp_t;

	typedef struct packed {
		logic [EW-1:0] start;
		logic [EW-1:0] len;
	} ent_t;

	localparam int ENT_W = 2 * EW;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_A_RD1,
		ST_A_DEC,
		ST_SD_START,
		ST_SD_LOOP,
		ST_F_CMP,
		ST_F_DEC,
		ST_SU_START,
		ST_SU_LOOP,
		ST_G_DEC,
		ST_G_ADD,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		RA_ZERO,
		RA_ONE,
		RA_IDX1,
		RA_IDX2,
		RA_IDXM1,
		RA_IDXM2,
		RA_LAST
	} rd_sel_t;

	typedef enum logic [3:0] {
		WR_ALLOC_MERGE,
		WR_ALLOC_SHRINK,
		WR_SHIFT,
		WR_FREE_JOIN,
		WR_FREE_FRONT,
		WR_FREE_BACK,
		WR_SINGLE,
		WR_GROW_EXT,
		WR_GROW_ADD
	} wr_sel_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_ONE,
		IDX_INC,
		IDX_DEC,
		IDX_CNT
	} idx_op_t;

	typedef enum logic [1:0] {
		STEP_HOLD,
		STEP_INC,
		STEP_DEC
	} step_t;

	typedef struct packed {
		logic    ready;
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		idx_op_t idx_op;
		logic    p_ld;
		logic    prev_ld;
		logic    cur_ld;
		logic    hold_ld;
		step_t   cnt_op;
		step_t   used_op;
		logic    cap_ld;
		logic    sts_ld;
		sts_t    sts;
		logic    out_ld;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic cnt_zero;
		logic cnt_full;
		logic cnt_gt1;
		logic len_gt1;
		logic alloc_merge;
		logic in_range;
		logic scan_lt;
		logic idx1_lt_cnt;
		logic idx2_lt_cnt;
		logic cur_front;
		logic cur_same;
		logic p_nz;
		logic prev_back;
		logic grow_le;
		logic last_at_cap;
		logic idx_eq_p;
		logic idx_gt_p1;
		logic out_free;
	} flags_t;

endpackage

[rtl/ifba_ram.sv]
// ----------------------------------------------------------------------------
// ifba_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ifba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/ifba_dp.sv]
// ----------------------------------------------------------------------------
// ifba_dp
// Datapath: interval table, counters, scan and shift address logic, result.
// ----------------------------------------------------------------------------
module ifba_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  ifba_pkg::cmd_t   cmd,
	input  ifba_pkg::req_t   req,
	output ifba_pkg::flags_t flags,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ifba_pkg::rsp_t   rsp
);
	import ifba_pkg::*;

	op_t                 op_q;
	logic [BLOCK_BITS-1:0] blk_q;
	logic [BLOCK_BITS-1:0] ncap_q;
	logic [CW-1:0]       cnt_q;
	logic [31:0]         used_q;
	logic [BLOCK_BITS-1:0] cap_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       p_q;
	ent_t                prev_q;
	ent_t                cur_q;
	logic                curv_q;
	ent_t                hold_q;
	logic [BLOCK_BITS-1:0] given_q;
	sts_t                sts_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	ent_t                rdata;
	ent_t                wdata;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       waddr;
	logic [CW-1:0]       rd_full;
	logic [CW-1:0]       wr_full;

	logic [EW-1:0]       n_ext;
	logic [EW-1:0]       diff_ext;
	logic [EW:0]         prev_end;
	logic [EW:0]         rd_end;
	logic [CW:0]         idx_w;
	logic [CW:0]         cnt_w;
	logic [CW:0]         p_w;

	assign n_ext    = EW'(blk_q);
	assign diff_ext = EW'(ncap_q - cap_q);
	assign prev_end = (EW+1)'(prev_q.start) + (EW+1)'(prev_q.len);
	assign rd_end   = (EW+1)'(rdata.start) + (EW+1)'(rdata.len);
	assign idx_w    = (CW+1)'(idx_q);
	assign cnt_w    = (CW+1)'(cnt_q);
	assign p_w      = (CW+1)'(p_q);

	always_comb begin
		flags.op          = op_q;
		flags.cnt_zero    = (cnt_q == '0);
		flags.cnt_full    = (cnt_q >= CNT_MAX);
		flags.cnt_gt1     = (cnt_q > CW'(1));
		flags.len_gt1     = (hold_q.len > EW'(1));
		flags.alloc_merge = ((EW+1)'(rdata.start) == (EW+1)'(hold_q.start) + (EW+1)'(1));
		flags.in_range    = (blk_q < cap_q);
		flags.scan_lt     = (rdata.start < n_ext);
		flags.idx1_lt_cnt = (idx_w + (CW+1)'(1) < cnt_w);
		flags.idx2_lt_cnt = (idx_w + (CW+1)'(2) < cnt_w);
		flags.cur_front   = curv_q && ((EW+1)'(cur_q.start) == (EW+1)'(n_ext) + (EW+1)'(1));
		flags.cur_same    = curv_q && (cur_q.start == n_ext);
		flags.p_nz        = (idx_q != '0);
		flags.prev_back   = (prev_end == (EW+1)'(blk_q));
		flags.grow_le     = (ncap_q <= cap_q);
		flags.last_at_cap = (rd_end == (EW+1)'(cap_q));
		flags.idx_eq_p    = (idx_q == p_q);
		flags.idx_gt_p1   = (idx_w > p_w + (CW+1)'(1));
		flags.out_free    = !rsp_valid_q || rsp_ready;
	end

	always_comb begin
		case (cmd.rd_sel)
			RA_ZERO:  rd_full = '0;
			RA_ONE:   rd_full = CW'(1);
			RA_IDX1:  rd_full = idx_q + CW'(1);
			RA_IDX2:  rd_full = idx_q + CW'(2);
			RA_IDXM1: rd_full = idx_q - CW'(1);
			RA_IDXM2: rd_full = idx_q - CW'(2);
			RA_LAST:  rd_full = cnt_q - CW'(1);
			default:  rd_full = '0;
		endcase
		raddr = rd_full[AW-1:0];
	end

	always_comb begin
		wr_full = idx_q;
		wdata   = rdata;
		case (cmd.wr_sel)
			WR_ALLOC_MERGE: begin
				wr_full     = '0;
				wdata.start = rdata.start;
				wdata.len   = hold_q.len - EW'(1);
			end
			WR_ALLOC_SHRINK: begin
				wr_full     = '0;
				wdata.start = hold_q.start + EW'(1);
				wdata.len   = hold_q.len - EW'(1);
			end
			WR_SHIFT: begin
				wr_full = idx_q;
				wdata   = rdata;
			end
			WR_FREE_JOIN: begin
				wr_full     = idx_q - CW'(1);
				wdata.start = prev_q.start;
				wdata.len   = prev_q.len + cur_q.len + EW'(1);
			end
			WR_FREE_FRONT: begin
				wr_full     = idx_q;
				wdata.start = n_ext;
				wdata.len   = cur_q.len + EW'(1);
			end
			WR_FREE_BACK: begin
				wr_full     = idx_q - CW'(1);
				wdata.start = prev_q.start;
				wdata.len   = prev_q.len + EW'(1);
			end
			WR_SINGLE: begin
				wr_full     = idx_q;
				wdata.start = n_ext;
				wdata.len   = EW'(1);
			end
			WR_GROW_EXT: begin
				wr_full     = cnt_q - CW'(1);
				wdata.start = rdata.start;
				wdata.len   = rdata.len + diff_ext;
			end
			WR_GROW_ADD: begin
				wr_full     = cnt_q;
				wdata.start = EW'(cap_q);
				wdata.len   = diff_ext;
			end
			default: begin
				wr_full = idx_q;
				wdata   = rdata;
			end
		endcase
		waddr = wr_full[AW-1:0];
	end

	ifba_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_INTERVALS)
	) u_table (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			used_q      <= '0;
			cap_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (cmd.cnt_op)
				STEP_INC: cnt_q <= cnt_q + CW'(1);
				STEP_DEC: cnt_q <= cnt_q - CW'(1);
				default:  cnt_q <= cnt_q;
			endcase
			case (cmd.used_op)
				STEP_INC: used_q <= used_q + 32'd1;
				STEP_DEC: used_q <= used_q - 32'd1;
				default:  used_q <= used_q;
			endcase
			if (cmd.cap_ld) begin
				cap_q <= ncap_q;
			end
			if (cmd.out_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(req.operation);
			blk_q   <= BLOCK_BITS'(req.block_number);
			ncap_q  <= BLOCK_BITS'(req.target_capacity);
			curv_q  <= 1'b0;
			given_q <= '0;
			sts_q   <= STS_OK;
		end else begin
			if (cmd.cur_ld) begin
				curv_q <= 1'b1;
			end
			if (cmd.hold_ld) begin
				given_q <= BLOCK_BITS'(rdata.start);
			end
			if (cmd.sts_ld) begin
				sts_q <= cmd.sts;
			end
		end
		case (cmd.idx_op)
			IDX_ZERO: idx_q <= '0;
			IDX_ONE:  idx_q <= CW'(1);
			IDX_INC:  idx_q <= idx_q + CW'(1);
			IDX_DEC:  idx_q <= idx_q - CW'(1);
			IDX_CNT:  idx_q <= cnt_q;
			default:  idx_q <= idx_q;
		endcase
		if (cmd.p_ld) begin
			p_q <= idx_q;
		end
		if (cmd.prev_ld) begin
			prev_q <= rdata;
		end
		if (cmd.cur_ld) begin
			cur_q <= rdata;
		end
		if (cmd.hold_ld) begin
			hold_q <= rdata;
		end
		if (cmd.out_ld) begin
			rsp_q.allocated_block <= 32'(given_q);
			rsp_q.status          <= sts_q;
			rsp_q.blocks_in_use   <= used_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule

[rtl/ifba_ctrl.sv]
// ----------------------------------------------------------------------------
// ifba_ctrl
// Sequencer: dispatch, table scan, shift down, shift up, grow and result hand-off.
// ----------------------------------------------------------------------------
module ifba_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  ifba_pkg::flags_t flags,
	output ifba_pkg::cmd_t   cmd
);
	import ifba_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_DISP;
			end
			ST_DISP: begin
				case (flags.op)
					OP_ALLOC: state_d = flags.cnt_zero ? ST_DONE : ST_A_RD1;
					OP_FREE: begin
						if (!flags.in_range) state_d = ST_DONE;
						else if (flags.cnt_zero) state_d = ST_F_DEC;
						else state_d = ST_F_CMP;
					end
					OP_GROW: begin
						if (flags.grow_le) state_d = ST_DONE;
						else if (flags.cnt_zero) state_d = ST_G_ADD;
						else state_d = ST_G_DEC;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_A_RD1: state_d = ST_A_DEC;
			ST_A_DEC: begin
				if (flags.len_gt1 && !(flags.cnt_gt1 && flags.alloc_merge)) state_d = ST_DONE;
				else state_d = ST_SD_START;
			end
			ST_SD_START: state_d = flags.idx1_lt_cnt ? ST_SD_LOOP : ST_DONE;
			ST_SD_LOOP: state_d = flags.idx2_lt_cnt ? ST_SD_LOOP : ST_DONE;
			ST_F_CMP: begin
				if (!flags.scan_lt || !flags.idx1_lt_cnt) state_d = ST_F_DEC;
			end
			ST_F_DEC: begin
				if (flags.cur_front) begin
					state_d = (flags.p_nz && flags.prev_back) ? ST_SD_START : ST_DONE;
				end else if ((flags.p_nz && flags.prev_back) || flags.cnt_full
						|| flags.cur_same) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SU_START;
				end
			end
			ST_SU_START: state_d = flags.idx_eq_p ? ST_DONE : ST_SU_LOOP;
			ST_SU_LOOP: state_d = flags.idx_gt_p1 ? ST_SU_LOOP : ST_SU_START;
			ST_G_DEC: state_d = flags.last_at_cap ? ST_DONE : ST_G_ADD;
			ST_G_ADD: state_d = ST_DONE;
			ST_DONE: begin
				if (flags.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_DISP: begin
				case (flags.op)
					OP_ALLOC: begin
						if (flags.cnt_zero) begin
							cmd.sts_ld = 1'b1;
							cmd.sts    = STS_NOSPACE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_ZERO;
						end
					end
					OP_FREE: begin
						cmd.idx_op = IDX_ZERO;
						if (flags.in_range && !flags.cnt_zero) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_ZERO;
						end
					end
					OP_GROW: begin
						if (flags.grow_le) begin
							cmd.sts_ld = 1'b1;
							cmd.sts    = STS_UNCHANGED;
						end else if (!flags.cnt_zero) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_LAST;
						end
					end
					default: cmd.sts = STS_OK;
				endcase
			end
			ST_A_RD1: begin
				// entry 0 is on the read port; fetch entry 1 behind it
				cmd.hold_ld = 1'b1;
				cmd.used_op = STEP_INC;
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RA_ONE;
			end
			ST_A_DEC: begin
				if (flags.len_gt1 && flags.cnt_gt1 && flags.alloc_merge) begin
					// shrunk head meets entry 1: keep one entry, drop the other
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_ALLOC_MERGE;
					cmd.idx_op = IDX_ONE;
				end else if (flags.len_gt1) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_ALLOC_SHRINK;
				end else begin
					cmd.idx_op = IDX_ZERO;
				end
			end
			ST_SD_START: begin
				if (flags.idx1_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX1;
				end else begin
					cmd.cnt_op = STEP_DEC;
				end
			end
			ST_SD_LOOP: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SHIFT;
				if (flags.idx2_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX2;
					cmd.idx_op = IDX_INC;
				end else begin
					cmd.cnt_op = STEP_DEC;
				end
			end
			ST_F_CMP: begin
				if (flags.scan_lt) begin
					cmd.prev_ld = 1'b1;
					cmd.idx_op  = IDX_INC;
					if (flags.idx1_lt_cnt) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RA_IDX1;
					end
				end else begin
					cmd.cur_ld = 1'b1;
				end
			end
			ST_F_DEC: begin
				if (flags.cur_front) begin
					cmd.used_op = STEP_DEC;
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = (flags.p_nz && flags.prev_back) ? WR_FREE_JOIN : WR_FREE_FRONT;
				end else if (flags.p_nz && flags.prev_back) begin
					cmd.used_op = STEP_DEC;
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = WR_FREE_BACK;
				end else if (flags.cnt_full) begin
					cmd.sts_ld = 1'b1;
					cmd.sts    = STS_FULL;
				end else if (flags.cur_same) begin
					cmd.used_op = STEP_DEC;
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = WR_SINGLE;
				end else begin
					cmd.used_op = STEP_DEC;
					cmd.p_ld    = 1'b1;
					cmd.idx_op  = IDX_CNT;
				end
			end
			ST_SU_START: begin
				if (flags.idx_eq_p) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_SINGLE;
					cmd.cnt_op = STEP_INC;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDXM1;
				end
			end
			ST_SU_LOOP: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SHIFT;
				cmd.idx_op = IDX_DEC;
				if (flags.idx_gt_p1) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDXM2;
				end
			end
			ST_G_DEC: begin
				if (flags.last_at_cap) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_GROW_EXT;
					cmd.cap_ld = 1'b1;
				end
			end
			ST_G_ADD: begin
				if (flags.cnt_full) begin
					cmd.sts_ld = 1'b1;
					cmd.sts    = STS_FULL;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_GROW_ADD;
					cmd.cnt_op = STEP_INC;
					cmd.cap_ld = 1'b1;
				end
			end
			ST_DONE: begin
				cmd.out_ld = flags.out_free;
			end
			default: cmd = '0;
		endcase
	end
endmodule

[rtl/interval_free_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// interval_free_block_allocator_core
// Free block allocator over a sorted table of free intervals with coalescing.
//
//   channel | dir | payload            | beat taken when
//   req     | in  | ifba_pkg::req_t    | req_valid & req_ready
//   rsp     | out | ifba_pkg::rsp_t    | rsp_valid & rsp_ready
//
// One request at a time, one response each. Operation time is set by the table's
// single read port (one entry per cycle in the scan and shifts).
// The response waits in an output register while the next request is taken;
// a second response then holds the block until the first beat leaves.
// No table clearing after reset: only entries below the interval count are used.
// ----------------------------------------------------------------------------
module interval_free_block_allocator_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ifba_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ifba_pkg::rsp_t rsp
);
	import ifba_pkg::*;

	cmd_t   cmd;
	flags_t flags;

	ifba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.flags    (flags),
		.cmd      (cmd)
	);

	ifba_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.flags    (flags),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	assign req_ready = cmd.ready;

`ifndef ASSERT_OFF
	a_no_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |-> !cmd.wr_en)
		else $error("table written while a request is taken");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		flags.cnt_full |-> (cmd.cnt_op != STEP_INC))
		else $error("interval count grows past the table size");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> flags.out_free)
		else $error("pending response overwritten");
`endif
endmodule
